// ===== src/etl_pkg.sv =====
// etl_pkg: shared types, token codes, keyword table and character class helpers
// used by the expression token lexer and its submodules; depends on nothing

package etl_pkg;

  // scan mode of the pending run
  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_WORD   = 2'd1,
    MODE_DIGITS = 2'd2
  } mode_t;

  // token kind codes
  localparam logic [4:0] KIND_IDENT   = 5'd0;
  localparam logic [4:0] KIND_NUMBER  = 5'd1;
  localparam logic [4:0] KIND_KW0     = 5'd2;
  localparam logic [4:0] KIND_PLUS    = 5'd9;
  localparam logic [4:0] KIND_MINUS   = 5'd10;
  localparam logic [4:0] KIND_STAR    = 5'd11;
  localparam logic [4:0] KIND_SLASH   = 5'd12;
  localparam logic [4:0] KIND_DOT     = 5'd13;
  localparam logic [4:0] KIND_LPAREN  = 5'd14;
  localparam logic [4:0] KIND_RPAREN  = 5'd15;
  localparam logic [4:0] KIND_INVALID = 5'd16;

  // keywords, first letter in the low byte
  localparam int KW_COUNT = 7;
  localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
    48'h0000_0052_4156,  // VAR
    48'h0000_0052_4F46,  // FOR
    48'h0045_4C49_4857,  // WHILE
    48'h0000_0000_4649,  // IF
    48'h0000_0000_4F44,  // DO
    48'h0000_0044_4E45,  // END
    48'h4E52_5554_4552   // RETURN
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd3, 4'd5, 4'd2, 4'd2, 4'd3, 4'd6
  };

  // result queue geometry
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] number;
    logic [55:0] text;
    logic [2:0]  length;
    logic        last;
  } token_t;

  // up to two tokens produced by one source byte
  typedef struct packed {
    logic [1:0] n;
    token_t     t0;
    token_t     t1;
  } push_t;

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0D || b == 8'h0A;
  endfunction

  function automatic logic [4:0] symbol_kind(input logic [7:0] b);
    logic [4:0] k;
    case (b)
      8'h2B:   k = KIND_PLUS;
      8'h2D:   k = KIND_MINUS;
      8'h2A:   k = KIND_STAR;
      8'h2F:   k = KIND_SLASH;
      8'h2E:   k = KIND_DOT;
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      default: k = KIND_INVALID;
    endcase
    return k;
  endfunction

endpackage

// ===== src/etl_core.sv =====
// etl_core: run state (mode, letter buffer, count, accumulator) and the
// per-byte decode that yields up to two tokens; depends on etl_pkg

module etl_core #(
  parameter int IDENT_BUFFER_SIZE = 8,
  parameter int NUMBER_WIDTH      = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [7:0]     src_byte,
  input  logic           src_eos,
  input  logic           take,
  output etl_pkg::push_t push
);

  localparam int CHARS = IDENT_BUFFER_SIZE - 1;
  localparam int BUF_W = 8 * CHARS;
  localparam int CNT_W = $clog2(IDENT_BUFFER_SIZE);

  etl_pkg::mode_t          mode, mode_next;
  logic [BUF_W-1:0]        letters, letters_next;
  logic [CNT_W-1:0]        count, count_next;
  logic [NUMBER_WIDTH-1:0] acc, acc_next;

  etl_pkg::token_t         old_tok, a_t, b_t, sym_tok;
  logic                    old_has, a_v, b_v;
  logic [BUF_W-1:0]        buf_base, new_buf;
  logic [CNT_W-1:0]        cnt_base, new_cnt;
  logic                    word_full;
  logic [NUMBER_WIDTH-1:0] acc_base, new_acc;

  // identifier or keyword token from a letter buffer
  function automatic etl_pkg::token_t word_token(input logic [BUF_W-1:0] b,
                                                 input logic [CNT_W-1:0] c);
    etl_pkg::token_t t;
    logic [63:0]     b64;
    logic [3:0]      c4;
    b64      = 64'(b);
    c4       = 4'(c);
    t.kind   = etl_pkg::KIND_IDENT;
    for (int k = 0; k < etl_pkg::KW_COUNT; k++) begin
      if (etl_pkg::KW_LEN[k] == c4 && {16'h0, etl_pkg::KW_TEXT[k]} == b64)
        t.kind = etl_pkg::KIND_KW0 + 5'(k);
    end
    t.number = '0;
    t.text   = b64[55:0];
    t.length = c4[2:0];
    t.last   = 1'b0;
    return t;
  endfunction

  // number token, low 32 bits of the accumulator
  function automatic etl_pkg::token_t num_token(input logic [NUMBER_WIDTH-1:0] a);
    etl_pkg::token_t t;
    logic [63:0]     a64;
    a64      = 64'(a);
    t.kind   = etl_pkg::KIND_NUMBER;
    t.number = a64[31:0];
    t.text   = '0;
    t.length = '0;
    t.last   = 1'b0;
    return t;
  endfunction

  // pending run as a token
  always_comb begin
    old_has = (mode == etl_pkg::MODE_WORD) || (mode == etl_pkg::MODE_DIGITS);
    if (mode == etl_pkg::MODE_WORD)
      old_tok = word_token(letters, count);
    else
      old_tok = num_token(acc);
  end

  // letter append and digit accumulate
  always_comb begin
    buf_base = (mode == etl_pkg::MODE_WORD) ? letters : '0;
    cnt_base = (mode == etl_pkg::MODE_WORD) ? count : '0;
    new_buf  = buf_base;
    for (int i = 0; i < CHARS; i++) begin
      if (cnt_base == CNT_W'(i))
        new_buf[8*i +: 8] = src_byte;
    end
    new_cnt   = cnt_base + CNT_W'(1);
    word_full = (new_cnt == CNT_W'(CHARS));
    acc_base  = (mode == etl_pkg::MODE_DIGITS) ? acc : '0;
    new_acc   = (acc_base << 3) + (acc_base << 1) + NUMBER_WIDTH'(src_byte[3:0]);
  end

  // single character token
  always_comb begin
    sym_tok        = '0;
    sym_tok.kind   = etl_pkg::symbol_kind(src_byte);
  end

  // token selection and next state
  always_comb begin
    a_v          = 1'b0;
    a_t          = old_tok;
    b_v          = 1'b0;
    b_t          = '0;
    mode_next    = etl_pkg::MODE_IDLE;
    letters_next = '0;
    count_next   = '0;
    acc_next     = '0;
    if (etl_pkg::is_letter(src_byte)) begin
      a_v = (mode == etl_pkg::MODE_DIGITS);
      if (word_full || src_eos) begin
        b_v = 1'b1;
        b_t = word_token(new_buf, new_cnt);
      end else begin
        mode_next    = etl_pkg::MODE_WORD;
        letters_next = new_buf;
        count_next   = new_cnt;
      end
    end else if (etl_pkg::is_digit(src_byte)) begin
      a_v = (mode == etl_pkg::MODE_WORD);
      if (src_eos) begin
        b_v = 1'b1;
        b_t = num_token(new_acc);
      end else begin
        mode_next = etl_pkg::MODE_DIGITS;
        acc_next  = new_acc;
      end
    end else if (etl_pkg::is_blank(src_byte)) begin
      a_v = old_has;
    end else begin
      a_v = old_has;
      b_v = 1'b1;
      b_t = sym_tok;
    end
    a_t.last = !b_v;
    b_t.last = 1'b1;
    push.n   = 2'(a_v) + 2'(b_v);
    push.t0  = a_v ? a_t : b_t;
    push.t1  = b_t;
  end

  // run state register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= etl_pkg::MODE_IDLE;
      letters <= '0;
      count   <= '0;
      acc     <= '0;
    end else if (take) begin
      mode    <= mode_next;
      letters <= letters_next;
      count   <= count_next;
      acc     <= acc_next;
    end
  end

  // end of source always leaves nothing pending
  a_eos_idle: assert property (@(posedge clk) disable iff (rst)
    (take && src_eos) |=> (mode == etl_pkg::MODE_IDLE && count == '0))
    else $error("run still pending after end of source");

endmodule

// ===== src/etl_tok_fifo.sv =====
// etl_tok_fifo: four-entry token queue, up to two writes and one read a cycle,
// presenting the head token to the output channel; depends on etl_pkg

module etl_tok_fifo (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push_en,
  input  etl_pkg::push_t              push,
  output logic [etl_pkg::FIFO_CW-1:0] free,
  output etl_pkg::token_t             head,
  output logic                        tok_valid,
  input  logic                        tok_stall
);

  etl_pkg::token_t              mem [etl_pkg::FIFO_DEPTH];
  logic [etl_pkg::FIFO_AW-1:0]  wr_ptr, rd_ptr;
  logic [etl_pkg::FIFO_CW-1:0]  count, count_next;
  logic [1:0]                   n_in;
  logic                         pop;

  assign n_in      = push_en ? push.n : 2'd0;
  assign tok_valid = (count != '0);
  assign pop       = tok_valid && !tok_stall;
  assign head      = mem[rd_ptr];
  assign free      = etl_pkg::FIFO_CW'(etl_pkg::FIFO_DEPTH) - count;
  assign count_next = count + etl_pkg::FIFO_CW'(n_in) - etl_pkg::FIFO_CW'(pop);

  // token storage
  always_ff @(posedge clk) begin
    if (n_in != 2'd0)
      mem[wr_ptr] <= push.t0;
    if (n_in == 2'd2)
      mem[wr_ptr + etl_pkg::FIFO_AW'(1)] <= push.t1;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + etl_pkg::FIFO_AW'(n_in);
      rd_ptr <= rd_ptr + etl_pkg::FIFO_AW'(pop);
      count  <= count_next;
    end
  end

  a_level: assert property (@(posedge clk) disable iff (rst)
    count <= etl_pkg::FIFO_CW'(etl_pkg::FIFO_DEPTH))
    else $error("token queue level out of range");

  a_room: assert property (@(posedge clk) disable iff (rst)
    (n_in != 2'd0) |-> (3'(n_in) <= free))
    else $error("token queue written without room");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (tok_valid && tok_stall && n_in == 2'd0) |=> (count == $past(count)))
    else $error("token queue level moved while stalled");

endmodule

// ===== src/expression_token_lexer.sv =====
// expression_token_lexer: top level with the source byte register, the run
// decoder and the token queue; depends on etl_pkg, etl_core, etl_tok_fifo
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------------
//  source   | src_valid / src_stall   | source_byte, end_of_source
//  token    | tok_valid / tok_stall   | token_kind, number_value, ident_text,
//           |                         | ident_length, last_of_run
//
// a byte is registered on acceptance and decoded the next cycle; its tokens
// are written into the token queue when taken and presented from its head
// one byte per cycle is taken while the four-entry token queue has room
// for the tokens of the registered byte; bytes giving two tokens drain at
// the output rate of one token per cycle while tok_stall is low
// synchronous reset empties the queue and clears any pending run
// a token stall backs up through the queue into src_stall

module expression_token_lexer #(
  parameter int IDENT_BUFFER_SIZE = 8,
  parameter int NUMBER_WIDTH      = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        src_valid,
  output logic        src_stall,
  input  logic [7:0]  source_byte,
  input  logic        end_of_source,
  output logic        tok_valid,
  input  logic        tok_stall,
  output logic [4:0]  token_kind,
  output logic [31:0] number_value,
  output logic [55:0] ident_text,
  output logic [2:0]  ident_length,
  output logic        last_of_run
);

  logic                        src_q_valid;
  logic [7:0]                  byte_q;
  logic                        eos_q;
  logic                        take;
  etl_pkg::push_t              push;
  logic [etl_pkg::FIFO_CW-1:0] free;
  etl_pkg::token_t             head;

  assign take      = src_q_valid && (etl_pkg::FIFO_CW'(push.n) <= free);
  assign src_stall = src_q_valid && !take;

  // source byte register
  always_ff @(posedge clk) begin
    if (rst)
      src_q_valid <= 1'b0;
    else if (!src_stall)
      src_q_valid <= src_valid;
  end

  always_ff @(posedge clk) begin
    if (src_valid && !src_stall) begin
      byte_q <= source_byte;
      eos_q  <= end_of_source;
    end
  end

  etl_core #(
    .IDENT_BUFFER_SIZE (IDENT_BUFFER_SIZE),
    .NUMBER_WIDTH      (NUMBER_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .src_byte (byte_q),
    .src_eos  (eos_q),
    .take     (take),
    .push     (push)
  );

  etl_tok_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_en   (take),
    .push      (push),
    .free      (free),
    .head      (head),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall)
  );

  // head token onto the ports
  assign token_kind   = head.kind;
  assign number_value = head.number;
  assign ident_text   = head.text;
  assign ident_length = head.length;
  assign last_of_run  = head.last;

endmodule

// ===== tb/expression_token_lexer_test.sv =====
// expression_token_lexer_test: self-checking bench for the expression token lexer,
// predicting every token from the byte stream and scoring the token channel in order
// depends on etl_pkg (mode_t, token_t, kind codes) and expression_token_lexer

module expression_token_lexer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDENT_BUFFER_SIZE = 8;
  localparam int ITEM_TARGET       = 750;

  // predicted token stream and field-by-field scoring
  class token_tracker;
    etl_pkg::mode_t  run_mode;
    logic [55:0]     letters;
    int              letter_total;
    logic [31:0]     digits_value;
    string           keywords[7];
    etl_pkg::token_t tokens_due[$];
    etl_pkg::token_t step_tokens[$];
    int              errors;
    int              bytes_seen;
    int              tokens_checked;
    int              keyword_tokens;
    int              double_steps;

    function new();
      keywords = '{"VAR", "FOR", "WHILE", "IF", "DO", "END", "RETURN"};
      run_mode = etl_pkg::MODE_IDLE;
      letters = '0;
      letter_total = 0;
      digits_value = '0;
    endfunction

    // exact, case-sensitive keyword lookup on the pending letters
    function logic [4:0] word_kind();
      logic [55:0] packed_word;
      for (int k = 0; k < 7; k++) begin
        packed_word = '0;
        for (int j = 0; j < keywords[k].len(); j++)
          packed_word[8*j +: 8] = keywords[k][j];
        if (keywords[k].len() == letter_total && packed_word == letters)
          return etl_pkg::KIND_KW0 + 5'(k);
      end
      return etl_pkg::KIND_IDENT;
    endfunction

    // emit whatever run is pending and return to idle
    function void flush_run();
      etl_pkg::token_t t;
      t = '0;
      if (run_mode == etl_pkg::MODE_WORD) begin
        t.kind = word_kind();
        t.text = letters;
        t.length = 3'(letter_total);
        if (t.kind != etl_pkg::KIND_IDENT) keyword_tokens++;
        step_tokens.push_back(t);
      end else if (run_mode == etl_pkg::MODE_DIGITS) begin
        t.kind = etl_pkg::KIND_NUMBER;
        t.number = digits_value;
        step_tokens.push_back(t);
      end
      run_mode = etl_pkg::MODE_IDLE;
      letters = '0;
      letter_total = 0;
      digits_value = '0;
    endfunction

    // one accepted source byte: work out the tokens it releases
    function void note_byte(logic [7:0] b, logic eos);
      etl_pkg::token_t t;
      step_tokens.delete();
      bytes_seen++;
      if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z")) begin
        if (run_mode != etl_pkg::MODE_WORD) flush_run();
        letters[8*letter_total +: 8] = b;
        letter_total++;
        run_mode = etl_pkg::MODE_WORD;
        // long runs are cut into chunks
        if (letter_total >= IDENT_BUFFER_SIZE - 1) flush_run();
      end else if (b >= "0" && b <= "9") begin
        if (run_mode != etl_pkg::MODE_DIGITS) flush_run();
        digits_value = digits_value * 32'd10 + {24'd0, b - "0"};
        run_mode = etl_pkg::MODE_DIGITS;
      end else if (b == 8'h20 || b == 8'h09 || b == 8'h0D || b == 8'h0A) begin
        flush_run();
      end else begin
        t = '0;
        case (b)
          "+":     t.kind = etl_pkg::KIND_PLUS;
          "-":     t.kind = etl_pkg::KIND_MINUS;
          "*":     t.kind = etl_pkg::KIND_STAR;
          "/":     t.kind = etl_pkg::KIND_SLASH;
          ".":     t.kind = etl_pkg::KIND_DOT;
          "(":     t.kind = etl_pkg::KIND_LPAREN;
          ")":     t.kind = etl_pkg::KIND_RPAREN;
          default: t.kind = etl_pkg::KIND_INVALID;
        endcase
        flush_run();
        step_tokens.push_back(t);
      end
      if (eos) flush_run();
      if (step_tokens.size() > 0)
        step_tokens[step_tokens.size()-1].last = 1'b1;
      if (step_tokens.size() > 1) double_steps++;
      foreach (step_tokens[i]) tokens_due.push_back(step_tokens[i]);
    endfunction

    task report(string what);
      errors++;
      // quiet after the first forty
      if (errors <= 40) $display("%0t ns: token mismatch: %s", $time, what);
    endtask

    // one accepted token against the oldest prediction
    task check_token(etl_pkg::token_t got);
      etl_pkg::token_t want;
      if (tokens_due.size() == 0) begin
        report($sformatf("token kind %0d with nothing predicted", got.kind));
        return;
      end
      want = tokens_due.pop_front();
      tokens_checked++;
      if (got.kind != want.kind)
        report($sformatf("kind %0d, predicted %0d", got.kind, want.kind));
      if (got.number != want.number)
        report($sformatf("number_value %0h, predicted %0h", got.number, want.number));
      if (got.text != want.text)
        report($sformatf("ident_text %0h, predicted %0h", got.text, want.text));
      if (got.length != want.length)
        report($sformatf("ident_length %0d, predicted %0d", got.length, want.length));
      if (got.last != want.last)
        report($sformatf("last_of_run %0b, predicted %0b", got.last, want.last));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        src_valid = 1'b0;
  logic        src_stall;
  logic [7:0]  source_byte = 8'h20;
  logic        end_of_source = 1'b0;
  logic        tok_valid;
  logic        tok_stall = 1'b0;
  logic [4:0]  token_kind;
  logic [31:0] number_value;
  logic [55:0] ident_text;
  logic [2:0]  ident_length;
  logic        last_of_run;

  token_tracker tracker = new();
  bit idling = 1'b1;
  int items_sent;
  int hold_asked;
  int hold_served;
  int long_hold;
  int stall_left;

  expression_token_lexer dut (
    .clk(clk),
    .rst(rst),
    .src_valid(src_valid),
    .src_stall(src_stall),
    .source_byte(source_byte),
    .end_of_source(end_of_source),
    .tok_valid(tok_valid),
    .tok_stall(tok_stall),
    .token_kind(token_kind),
    .number_value(number_value),
    .ident_text(ident_text),
    .ident_length(ident_length),
    .last_of_run(last_of_run)
  );

  always #5 clk = ~clk;

  // offer one request and hold it until taken, then maybe idle
  task send_byte(input logic [7:0] b, input logic eos);
    source_byte <= b;
    end_of_source <= eos;
    src_valid <= 1'b1;
    do @(posedge clk); while (src_stall);
    tracker.note_byte(b, eos);
    items_sent++;
    if (idling && $urandom_range(0, 4) == 0) begin
      src_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // send a string, end of source now and then when odds is non-zero
  task send_text(input string s, input int odds);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], odds != 0 && $urandom_range(1, odds) == 1);
  endtask

  // sender goes quiet until every predicted token has come out
  task pause_until_drained();
    src_valid <= 1'b0;
    while (tracker.tokens_due.size() != 0) @(posedge clk);
  endtask

  // mostly well-formed words, numbers and operators, with some noise
  task send_random(input int upto);
    string s;
    string ops;
    int    n;
    ops = "+-*/.()";
    while (items_sent < upto) begin
      s = "";
      case ($urandom_range(0, 9))
        0, 1: begin
          s = tracker.keywords[$urandom_range(0, 6)];
          case ($urandom_range(0, 5))
            0: s = s.tolower();
            1: s = {s, "S"};
            2: s = s.substr(0, s.len() - 2);
            default: ;
          endcase
        end
        2, 3: begin
          n = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
          repeat (n) begin
            if ($urandom_range(0, 1)) s = {s, string'(8'("A" + $urandom_range(0, 25)))};
            else s = {s, string'(8'("a" + $urandom_range(0, 25)))};
          end
        end
        4, 5: begin
          n = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 4);
          repeat (n) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
        end
        6: s = string'(ops[$urandom_range(0, 6)]);
        7: begin
          case ($urandom_range(0, 3))
            0: send_byte(8'h20, 1'b0);
            1: send_byte(8'h09, 1'b0);
            2: send_byte(8'h0D, 1'b0);
            default: send_byte(8'h0A, 1'b0);
          endcase
        end
        default: send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      endcase
      if (s.len() > 0) send_text(s, 25);
      if ($urandom_range(0, 1)) send_byte(8'h20, $urandom_range(0, 19) == 0);
    end
  endtask

  // token sink: score accepted tokens and drive the stall
  initial begin : token_sink
    forever begin
      @(posedge clk);
      if (!rst && tok_valid && !tok_stall)
        tracker.check_token('{kind: token_kind, number: number_value, text: ident_text,
                               length: ident_length, last: last_of_run});
      if (hold_asked != hold_served) begin
        hold_served = hold_asked;
        long_hold = 48;
      end
      if (long_hold > 0) begin
        long_hold--;
        tok_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        tok_stall <= 1'b1;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);
        tok_stall <= 1'b1;
      end else begin
        tok_stall <= 1'b0;
      end
    end
  end

  // main sequence
  initial begin : source_feed
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: chunked run, keyword ended by digit, two-token bytes, every
    // operator, the blanks and unknown bytes on both sides of the upper-case letters
    send_text("Zazyxwv", 0);
    send_text("IF09()+-*/.", 0);
    send_byte(8'h20, 1'b0);
    send_byte(8'h09, 1'b0);
    send_byte(8'h0D, 1'b0);
    send_byte(8'h0A, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte("@", 1'b0);
    send_text("q", 0);
    send_byte("[", 1'b1);

    send_random(250);

    // receiver holds off while the sender keeps going, then a full drain
    idling = 1'b0;
    hold_asked++;
    send_random(300);
    pause_until_drained();
    idling = 1'b1;

    send_random(650);

    // closing stretch at full rate
    idling = 1'b0;
    send_random(ITEM_TARGET);
    send_byte("x", 1'b1);

    pause_until_drained();
    repeat (10) @(posedge clk);

    $display("covered %0d source bytes and %0d tokens, %0d of them keywords,",
             tracker.bytes_seen, tracker.tokens_checked, tracker.keyword_tokens);
    $display("with %0d bytes giving two tokens", tracker.double_steps);
    if (tracker.errors == 0) begin
      $display("expression_token_lexer verification clean");
    end else begin
      $display("expression_token_lexer verification failed");
    end
    $finish;
  end

  // run limit
  initial begin : run_limit
    #2ms;
    $display("expression_token_lexer verification failed");
    $finish;
  end

endmodule
